FILE: rtl/plf_pkg.sv
// ----------------------------------------------------------------------------
// plf_pkg
// Shared types and constants of the principal-axis line fit block.
// ----------------------------------------------------------------------------
`default_nettype none

package plf_pkg;

  // coordinate width on the channel, and width of the post-processing words
  localparam int IN_COORD_W = 8;
  localparam int WORD_W     = 64;
  localparam int RES_W      = 32;
  localparam int Q_FRAC     = 16;
  localparam int NORM_BIT   = 30;

  localparam logic [RES_W-1:0] SAT_MAG = 32'h7FFF_FFFF;
  localparam logic [RES_W-1:0] ALL_ONE = 32'hFFFF_FFFF;

  // operations of the serial arithmetic unit
  typedef enum logic [1:0] {
    AOP_MUL,
    AOP_DIV,
    AOP_SQRT
  } arith_op_t;

  // steps of the end-of-set computation
  typedef enum logic [3:0] {
    ST_NXX,
    ST_SXX,
    ST_NYY,
    ST_SYY,
    ST_NXY,
    ST_SXY,
    ST_NORM,
    ST_AMC2,
    ST_BB,
    ST_SQRT,
    ST_SLMAJ,
    ST_SLMIN,
    ST_ICMAJ_MUL,
    ST_ICMAJ_DIV,
    ST_ICMIN_MUL,
    ST_ICMIN_DIV
  } step_t;

  // controller states
  typedef enum logic [2:0] {
    S_ACCUM,
    S_CHECK,
    S_ISSUE,
    S_WAIT,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic  start;
    step_t step;
    logic  load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic step_done;
    logic empty;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/plf_in_if.sv
// ----------------------------------------------------------------------------
// plf_in_if
// Point channel: one image point or end marker per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface plf_in_if;
  logic       valid;
  logic       ready;
  logic       point_present;
  logic [7:0] x_coord;
  logic [7:0] y_coord;
  logic       last_point;

  modport source (output valid, point_present, x_coord, y_coord, last_point,
                  input ready);
  modport sink (input valid, point_present, x_coord, y_coord, last_point,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/plf_out_if.sv
// ----------------------------------------------------------------------------
// plf_out_if
// Result channel: the two fitted lines of one point set per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface plf_out_if;
  logic               valid;
  logic               ready;
  logic               set_empty;
  logic               points_dropped;
  logic signed [31:0] slope_major;
  logic signed [31:0] intercept_major;
  logic signed [31:0] slope_minor;
  logic signed [31:0] intercept_minor;

  modport source (output valid, set_empty, points_dropped, slope_major,
                  intercept_major, slope_minor, intercept_minor,
                  input ready);
  modport sink (input valid, set_empty, points_dropped, slope_major,
                intercept_major, slope_minor, intercept_minor,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/pca_point_set_line_fit.sv
// ----------------------------------------------------------------------------
// pca_point_set_line_fit
// Principal-axis line fit of a 2-D point set.
// ----------------------------------------------------------------------------
// Points are taken one per cycle and only update the count and the sums of x,
// y, x*x, y*y and x*y. The item marked last closes the set: the block stops
// taking points while it forms the scatter matrix, normalizes it, takes the
// eigen directions with an integer square root and produces slope and
// intercept (signed Q16.16) of the major and then the minor axis, as one
// result item. The multiplies, divides and the square root run on one shared
// bit-serial arithmetic unit; the normalizing shifts are done in the datapath,
// and a slope whose divisor or P is zero skips its divide. An empty set skips
// the computation and answers with set_empty and all-ones result fields.
// Points taken while MAX_POINTS are already held are dropped and flagged.
// ----------------------------------------------------------------------------
`default_nettype none

module pca_point_set_line_fit
  import plf_pkg::*;
#(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  plf_in_if.sink    in_ch,
  plf_out_if.source out_ch
);

  logic     in_fire;
  logic     in_ready;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;

  plf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_last  (in_ch.last_point),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  plf_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_fire             (in_fire),
    .in_point_present    (in_ch.point_present),
    .in_x_coord          (in_ch.x_coord),
    .in_y_coord          (in_ch.y_coord),
    .cmd                 (cmd),
    .stat                (stat),
    .out_ready           (out_ch.ready),
    .out_valid           (out_ch.valid),
    .out_set_empty       (out_ch.set_empty),
    .out_points_dropped  (out_ch.points_dropped),
    .out_slope_major     (out_ch.slope_major),
    .out_intercept_major (out_ch.intercept_major),
    .out_slope_minor     (out_ch.slope_minor),
    .out_intercept_minor (out_ch.intercept_minor)
  );

endmodule

`default_nettype wire

FILE: rtl/plf_arith.sv
// ----------------------------------------------------------------------------
// plf_arith
// Serial arithmetic unit: 64-bit modular multiply, restoring divide and
// integer square root, one bit (or one root digit) per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module plf_arith
  import plf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  arith_op_t         op,
  input  logic [WORD_W-1:0] opa,
  input  logic [WORD_W-1:0] opb,
  output logic              done,
  output logic [WORD_W-1:0] result
);

  localparam int CNT_W = $clog2(WORD_W);

  logic              busy_r;
  logic              done_r;
  arith_op_t         op_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [WORD_W-1:0] acc_r;
  logic [WORD_W-1:0] a_r;
  logic [WORD_W-1:0] b_r;
  logic [WORD_W:0]   rem_r;

  // one divide step
  logic [WORD_W:0]   rem_sh;
  logic              q_bit;
  // one root step
  logic [WORD_W-1:0] root_try;
  logic              root_fit;

  always_comb begin
    rem_sh   = {rem_r[WORD_W-1:0], a_r[WORD_W-1]};
    q_bit    = (rem_sh >= {1'b0, b_r});
    root_try = acc_r + b_r;
    root_fit = (a_r >= root_try);
  end

  // sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= (op == AOP_SQRT) ? CNT_W'(WORD_W / 2 - 1) : CNT_W'(WORD_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operand and result registers
  always_ff @(posedge clk) begin
    if (start) begin
      op_r  <= op;
      acc_r <= '0;
      a_r   <= opa;
      rem_r <= '0;
      b_r   <= (op == AOP_SQRT) ? (WORD_W'(1) << (WORD_W - 2)) : opb;
    end else if (busy_r) begin
      unique case (op_r)
        AOP_MUL: begin
          if (b_r[0]) acc_r <= acc_r + a_r;
          a_r <= a_r << 1;
          b_r <= b_r >> 1;
        end
        AOP_DIV: begin
          rem_r <= q_bit ? (rem_sh - {1'b0, b_r}) : rem_sh;
          acc_r <= {acc_r[WORD_W-2:0], q_bit};
          a_r   <= a_r << 1;
        end
        AOP_SQRT: begin
          if (root_fit) begin
            a_r   <= a_r - root_try;
            acc_r <= (acc_r >> 1) + b_r;
          end else begin
            acc_r <= acc_r >> 1;
          end
          b_r <= b_r >> 2;
        end
        default: acc_r <= acc_r;
      endcase
    end
  end

  assign done   = done_r;
  assign result = acc_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("arith unit started while busy");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("arith done without a finished run");

endmodule

`default_nettype wire

FILE: rtl/plf_dp.sv
// ----------------------------------------------------------------------------
// plf_dp
// Datapath: point accumulators, scatter matrix and line registers, the
// serial arithmetic unit and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module plf_dp
  import plf_pkg::*;
#(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_fire,
  input  logic                  in_point_present,
  input  logic [IN_COORD_W-1:0] in_x_coord,
  input  logic [IN_COORD_W-1:0] in_y_coord,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  out_set_empty,
  output logic                  out_points_dropped,
  output logic signed [RES_W-1:0] out_slope_major,
  output logic signed [RES_W-1:0] out_intercept_major,
  output logic signed [RES_W-1:0] out_slope_minor,
  output logic signed [RES_W-1:0] out_intercept_minor
);

  localparam int XW    = (COORD_BITS < IN_COORD_W) ? COORD_BITS : IN_COORD_W;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SX_W  = XW + CNT_W;
  localparam int SQ_W  = 2 * XW + CNT_W;

  // saturate a quotient magnitude and apply its sign
  function automatic logic [RES_W-1:0] sat_q(input logic neg, input logic [WORD_W-1:0] q);
    logic [RES_W-1:0] mag;
    mag = (q > WORD_W'(SAT_MAG)) ? SAT_MAG : q[RES_W-1:0];
    return neg ? (~mag + 1'b1) : mag;
  endfunction

  // accumulators
  logic [CNT_W-1:0] n_r;
  logic [SX_W-1:0]  sx_r, sy_r;
  logic [SQ_W-1:0]  sxx_r, syy_r, sxy_r;
  logic             ovf_r;

  // working registers
  logic [WORD_W-1:0] t0_r, t1_r, a_r, c_r, b_r, p_r;
  logic              bneg_r;
  logic [RES_W-1:0]  slmaj_r, slmin_r, icmaj_r, icmin_r;

  // output register
  logic              out_valid_r;
  logic              out_empty_r, out_drop_r;
  logic [RES_W-1:0]  out_slmaj_r, out_icmaj_r, out_slmin_r, out_icmin_r;

  // arith unit
  logic              ar_start, ar_done;
  arith_op_t         ar_op;
  logic [WORD_W-1:0] ar_a, ar_b, ar_res;

  logic [XW-1:0]     px, py;
  logic              full;
  logic [WORD_W-1:0] n_w, sx_w, sy_w, half_n;
  logic              norm_big, age;
  logic [WORD_W-1:0] amc, two_b, num, den;
  logic              slope_step, bypass;
  logic [RES_W-1:0]  cur_sl, sl_abs, slope_val;
  logic [WORD_W-1:0] smag, sy16, ic_mag;
  logic              ic_neg;

  assign px     = in_x_coord[XW-1:0];
  assign py     = in_y_coord[XW-1:0];
  assign full   = (n_r == CNT_W'(MAX_POINTS));
  assign n_w    = WORD_W'(n_r);
  assign sx_w   = WORD_W'(sx_r);
  assign sy_w   = WORD_W'(sy_r);
  assign half_n = n_w >> 1;

  // derived values of the normalized matrix
  always_comb begin
    norm_big = |(a_r[WORD_W-1:NORM_BIT] | c_r[WORD_W-1:NORM_BIT] | b_r[WORD_W-1:NORM_BIT]);
    age      = (a_r >= c_r);
    amc      = age ? (a_r - c_r) : (c_r - a_r);
    two_b    = b_r << 1;
    // major takes 2B/P when A >= C, the minor axis the reverse
    if ((cmd.step == ST_SLMAJ) == age) begin
      num = two_b;
      den = p_r;
    end else begin
      num = p_r;
      den = two_b;
    end
    slope_step = (cmd.step == ST_SLMAJ) || (cmd.step == ST_SLMIN);
  end

  // intercept terms for the slope in use
  always_comb begin
    cur_sl = ((cmd.step == ST_ICMAJ_MUL) || (cmd.step == ST_ICMAJ_DIV)) ? slmaj_r : slmin_r;
    sl_abs = cur_sl[RES_W-1] ? (~cur_sl + 1'b1) : cur_sl;
    smag   = WORD_W'(sl_abs);
    sy16   = sy_w << Q_FRAC;
    priority if (cur_sl[RES_W-1]) begin
      ic_mag = sy16 + t0_r;
      ic_neg = 1'b0;
    end else if (sy16 >= t0_r) begin
      ic_mag = sy16 - t0_r;
      ic_neg = 1'b0;
    end else begin
      ic_mag = t0_r - sy16;
      ic_neg = 1'b1;
    end
  end

  // operand selection per step
  always_comb begin
    ar_op = AOP_MUL;
    ar_a  = '0;
    ar_b  = '0;
    unique case (cmd.step)
      ST_NXX:       begin ar_a = n_w;  ar_b = WORD_W'(sxx_r); end
      ST_SXX:       begin ar_a = sx_w; ar_b = sx_w;           end
      ST_NYY:       begin ar_a = n_w;  ar_b = WORD_W'(syy_r); end
      ST_SYY:       begin ar_a = sy_w; ar_b = sy_w;           end
      ST_NXY:       begin ar_a = n_w;  ar_b = WORD_W'(sxy_r); end
      ST_SXY:       begin ar_a = sx_w; ar_b = sy_w;           end
      ST_NORM:      begin ar_a = '0;   ar_b = '0;             end
      ST_AMC2:      begin ar_a = amc;  ar_b = amc;            end
      ST_BB:        begin ar_a = b_r;  ar_b = b_r;            end
      ST_SQRT:      begin ar_op = AOP_SQRT; ar_a = t1_r;      end
      ST_SLMAJ, ST_SLMIN: begin
        ar_op = AOP_DIV;
        ar_a  = (num << Q_FRAC) + (den >> 1);
        ar_b  = den;
      end
      ST_ICMAJ_MUL, ST_ICMIN_MUL: begin ar_a = smag; ar_b = sx_w; end
      ST_ICMAJ_DIV, ST_ICMIN_DIV: begin
        ar_op = AOP_DIV;
        ar_a  = ic_mag + half_n;
        ar_b  = n_w;
      end
      default: ar_a = '0;
    endcase
  end

  // steps that finish without the arith unit
  always_comb begin
    bypass = 1'b0;
    if (cmd.step == ST_NORM) bypass = !norm_big;
    else if (slope_step) bypass = (p_r == '0) || (den == '0);
  end

  assign ar_start       = cmd.start && !bypass && (cmd.step != ST_NORM);
  assign stat.step_done = (cmd.start && bypass) || ar_done;
  assign stat.empty     = (n_r == '0);
  assign stat.out_free  = !out_valid_r || out_ready;

  // slope value written back by a slope step
  always_comb begin
    slope_val = '0;
    if (cmd.step == ST_SLMAJ) begin
      priority if (p_r == '0) slope_val = '0;
      else if (den == '0) slope_val = SAT_MAG;
      else slope_val = sat_q(bneg_r, ar_res);
    end else begin
      priority if (p_r == '0) slope_val = SAT_MAG;
      else if (den == '0) slope_val = SAT_MAG;
      else slope_val = sat_q(!bneg_r, ar_res);
      // no cross term and a flat major axis: the minor axis is vertical
      if (slmaj_r == '0 && b_r == '0) slope_val = SAT_MAG;
    end
  end

  plf_arith u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ar_start),
    .op     (ar_op),
    .opa    (ar_a),
    .opb    (ar_b),
    .done   (ar_done),
    .result (ar_res)
  );

  // accumulators and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= '0;
      sx_r        <= '0;
      sy_r        <= '0;
      sxx_r       <= '0;
      syy_r       <= '0;
      sxy_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
        n_r         <= '0;
        sx_r        <= '0;
        sy_r        <= '0;
        sxx_r       <= '0;
        syy_r       <= '0;
        sxy_r       <= '0;
        ovf_r       <= 1'b0;
      end else begin
        if (out_ready) out_valid_r <= 1'b0;
        if (in_fire && in_point_present) begin
          if (full) begin
            ovf_r <= 1'b1;
          end else begin
            n_r   <= n_r + 1'b1;
            sx_r  <= sx_r + SX_W'(px);
            sy_r  <= sy_r + SX_W'(py);
            sxx_r <= sxx_r + SQ_W'(px) * SQ_W'(px);
            syy_r <= syy_r + SQ_W'(py) * SQ_W'(py);
            sxy_r <= sxy_r + SQ_W'(px) * SQ_W'(py);
          end
        end
      end
    end
  end

  // step write-back
  always_ff @(posedge clk) begin
    if (cmd.start && cmd.step == ST_NORM) begin
      if (norm_big) begin
        a_r <= a_r >> 1;
        c_r <= c_r >> 1;
        b_r <= b_r >> 1;
      end else if (b_r == '0) begin
        bneg_r <= 1'b0;
      end
    end
    if (stat.step_done) begin
      unique case (cmd.step)
        ST_NXX, ST_NYY, ST_NXY, ST_AMC2: t0_r <= ar_res;
        ST_SXX:  a_r <= t0_r - ar_res;
        ST_SYY:  c_r <= t0_r - ar_res;
        ST_SXY: begin
          bneg_r <= (t0_r < ar_res);
          b_r    <= (t0_r < ar_res) ? (ar_res - t0_r) : (t0_r - ar_res);
        end
        ST_NORM: t1_r <= t1_r;
        ST_BB:   t1_r <= t0_r + (ar_res << 2);
        ST_SQRT: p_r  <= ar_res + amc;
        ST_SLMAJ: slmaj_r <= slope_val;
        ST_SLMIN: slmin_r <= slope_val;
        ST_ICMAJ_MUL, ST_ICMIN_MUL: t0_r <= ar_res;
        ST_ICMAJ_DIV: icmaj_r <= sat_q(ic_neg, ar_res);
        ST_ICMIN_DIV: icmin_r <= sat_q(ic_neg, ar_res);
        default: t0_r <= t0_r;
      endcase
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_empty_r <= stat.empty;
      out_drop_r  <= ovf_r;
      out_slmaj_r <= stat.empty ? ALL_ONE : slmaj_r;
      out_icmaj_r <= stat.empty ? ALL_ONE : icmaj_r;
      out_slmin_r <= stat.empty ? ALL_ONE : slmin_r;
      out_icmin_r <= stat.empty ? ALL_ONE : icmin_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_set_empty       = out_empty_r;
  assign out_points_dropped  = out_drop_r;
  assign out_slope_major     = out_slmaj_r;
  assign out_intercept_major = out_icmaj_r;
  assign out_slope_minor     = out_slmin_r;
  assign out_intercept_minor = out_icmin_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> stat.out_free)
    else $error("result loaded over an untaken item");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(MAX_POINTS))
    else $error("point count beyond capacity");

endmodule

`default_nettype wire

FILE: rtl/plf_ctrl.sv
// ----------------------------------------------------------------------------
// plf_ctrl
// Controller: takes points until the last item, then walks the datapath
// through the fit steps and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module plf_ctrl
  import plf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     in_last,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;
  step_t  step_after;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACCUM;
      step_r  <= ST_NXX;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // fixed order of the fit steps
  always_comb begin
    unique case (step_r)
      ST_NXX:       step_after = ST_SXX;
      ST_SXX:       step_after = ST_NYY;
      ST_NYY:       step_after = ST_SYY;
      ST_SYY:       step_after = ST_NXY;
      ST_NXY:       step_after = ST_SXY;
      ST_SXY:       step_after = ST_NORM;
      ST_NORM:      step_after = ST_AMC2;
      ST_AMC2:      step_after = ST_BB;
      ST_BB:        step_after = ST_SQRT;
      ST_SQRT:      step_after = ST_SLMAJ;
      ST_SLMAJ:     step_after = ST_SLMIN;
      ST_SLMIN:     step_after = ST_ICMAJ_MUL;
      ST_ICMAJ_MUL: step_after = ST_ICMAJ_DIV;
      ST_ICMAJ_DIV: step_after = ST_ICMIN_MUL;
      ST_ICMIN_MUL: step_after = ST_ICMIN_DIV;
      ST_ICMIN_DIV: step_after = ST_NXX;
      default:      step_after = ST_NXX;
    endcase
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    in_ready     = 1'b0;
    cmd.start    = 1'b0;
    cmd.step     = step_r;
    cmd.load_out = 1'b0;
    unique case (state_r)
      S_ACCUM: begin
        in_ready = 1'b1;
        if (in_fire && in_last) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        step_nxt  = ST_NXX;
        state_nxt = stat.empty ? S_OUT : S_ISSUE;
      end
      S_ISSUE: begin
        cmd.start = 1'b1;
        if (stat.step_done) begin
          step_nxt  = step_after;
          state_nxt = (step_r == ST_ICMIN_DIV) ? S_OUT : S_ISSUE;
        end else if (step_r != ST_NORM) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (stat.step_done) begin
          step_nxt  = step_after;
          state_nxt = (step_r == ST_ICMIN_DIV) ? S_OUT : S_ISSUE;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_ACCUM;
        end
      end
      default: state_nxt = S_ACCUM;
    endcase
  end

  a_out_return: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && stat.out_free) |=> state_r == S_ACCUM && !$past(in_ready))
    else $error("controller did not return to accumulation after result");

endmodule

`default_nettype wire
